FILE: src/nre_pkg.sv
// Shared types, constants and helpers of the numeric record encoder.
`default_nettype none
package nre_pkg;

    localparam int unsigned DELTA_W   = 32;
    localparam int unsigned VALUE_W   = 64;
    localparam int unsigned S_DATA_W  = 96;
    localparam int unsigned M_DATA_W  = 112;

    localparam logic [10:0] EXP_SPECIAL = 11'h7FF;
    localparam logic [63:0] TINY_LIMIT  = 64'd7;
    localparam logic [31:0] F32_INF     = 32'h7F80_0000;
    // significand of the double closest to 0.01, scaled by 2^-59
    localparam logic [52:0] ERR_MANT    = 53'h147AE147AE147B;

    localparam logic [3:0] PLEN_NONE   = 4'd0;
    localparam logic [3:0] PLEN_FLOAT  = 4'd4;
    localparam logic [3:0] PLEN_DOUBLE = 4'd8;

    typedef struct packed {
        logic        is_inf;
        logic        is_int;
        logic        is_tiny;
        logic [63:0] mag_int;
        logic [3:0]  int_len;
    } t_cls;

    typedef struct packed {
        logic [31:0] fbits;
        logic        use_double;
    } t_flt;

    function automatic logic [3:0] byte_len64(input logic [63:0] v);
        logic [3:0] n;
        n = 4'd1;
        for (int b = 1; b < 8; b++) begin
            if (v[8*b +: 8] != 8'd0) n = 4'(b + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: src/numeric_record_encoder.sv
// Numeric record encoder top level: input register, coding logic, result register.
// Each record passes the input register and then the result register before its result request.
// Throughput: one record per cycle unless the output stalls; coding is fixed logic between two registers.
// Stalls on the output side hold both stages; input tready follows the pipeline enable.
// Reset (synchronous, active low) clears both valid flags; payload registers are not reset.
`default_nettype none
module numeric_record_encoder
    import nre_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    // [31:0] delta, [95:32] value_bits
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    output      logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [7:0] header_byte, [10:8] delta_length, [42:11] delta_copy,
    // [106:43] payload, [110:107] payload_length, [111] zero
    output      logic [M_DATA_W-1:0] m_axis_tdata
);
    logic                r_in_valid, r_out_valid;
    logic [S_DATA_W-1:0] r_in;
    logic [M_DATA_W-1:0] r_out, n_out;
    logic                en;
    t_cls                cls;
    t_flt                flt;
    logic [31:0]         delta;
    logic [63:0]         vb;
    logic [7:0]          hdr;
    logic [2:0]          dlen;
    logic [63:0]         payload;
    logic [3:0]          plen;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign delta         = r_in[31:0];
    assign vb            = r_in[95:32];

    nre_classify u_cls (.i_value_bits(vb), .o_cls(cls));
    nre_f32      u_f32 (.i_mag(vb[62:0]), .o_flt(flt));

    always_comb begin
        dlen = 3'd1;
        for (int b = 1; b < 4; b++) begin
            if (delta[8*b +: 8] != 8'd0) dlen = 3'(b + 1);
        end
        hdr     = {6'd0, 2'(dlen - 3'd1)};
        payload = '0;
        plen    = PLEN_NONE;
        if (cls.is_inf) begin
            hdr[2] = 1'b1;
            hdr[3] = 1'b1;
            hdr[4] = vb[63] && (vb[51:0] == 52'd0);
        end else if (cls.is_tiny) begin
            hdr[3]   = 1'b1;
            hdr[7:4] = cls.mag_int[3:0];
        end else if (cls.is_int) begin
            hdr[6:4] = 3'(cls.int_len - 4'd1);
            hdr[7]   = vb[63];
            payload  = cls.mag_int;
            plen     = cls.int_len;
        end else begin
            hdr[2] = 1'b1;
            hdr[4] = vb[63];
            hdr[5] = flt.use_double;
            if (flt.use_double) begin
                payload = {1'b0, vb[62:0]};
                plen    = PLEN_DOUBLE;
            end else begin
                payload = {32'd0, flt.fbits};
                plen    = PLEN_FLOAT;
            end
        end
        n_out = {1'b0, plen, payload, delta, dlen, hdr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_in_valid  <= s_axis_tvalid;
            r_out_valid <= r_in_valid;
        end
        if (en) begin
            r_in  <= s_axis_tdata;
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    a_dlen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:8] != 3'd0 && m_axis_tdata[10:8] <= 3'd4))
        else $error("delta length out of range");
    a_dlen_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (3'(m_axis_tdata[1:0]) + 3'd1 == m_axis_tdata[10:8]))
        else $error("header delta field disagrees with delta length");
    a_float_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[2] && !m_axis_tdata[3]) |->
        (m_axis_tdata[110:107] == PLEN_FLOAT || m_axis_tdata[110:107] == PLEN_DOUBLE))
        else $error("float record with bad payload length");
    a_tiny_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[3]) |-> (m_axis_tdata[110:107] == PLEN_NONE))
        else $error("tiny or infinity record carries payload");
    a_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !en) |=> r_in_valid)
        else $error("input stage lost an item during stall");
`endif
endmodule
`default_nettype wire

FILE: src/nre_classify.sv
// Value classifier: infinity or NaN, exact integer, tiny integer and the integer magnitude.
`default_nettype none
module nre_classify
    import nre_pkg::*;
(
    input  wire logic [63:0] i_value_bits,
    output t_cls             o_cls
);
    logic [10:0] e;
    logic [52:0] sig;
    logic [63:0] u;
    logic        is_int;
    logic [5:0]  sh;
    logic [52:0] low_mask;

    always_comb begin
        e        = i_value_bits[62:52];
        sig      = {1'b1, i_value_bits[51:0]};
        u        = '0;
        is_int   = 1'b0;
        sh       = '0;
        low_mask = '0;
        if (e == 11'd0) begin
            is_int = (i_value_bits[51:0] == 52'd0);
        end else if (e >= 11'd1075 && e <= 11'd1086) begin
            u      = {11'd0, sig} << (e - 11'd1075);
            is_int = 1'b1;
        end else if (e >= 11'd1023 && e < 11'd1075) begin
            sh       = 6'(11'd1075 - e);
            low_mask = (53'd1 << sh) - 53'd1;
            if ((sig & low_mask) == 53'd0) begin
                u      = 64'(sig >> sh);
                is_int = 1'b1;
            end
        end
        o_cls.is_inf  = (e == EXP_SPECIAL);
        o_cls.is_int  = is_int && (e != EXP_SPECIAL);
        o_cls.is_tiny = is_int && (u <= TINY_LIMIT) && (!i_value_bits[63] || u == 64'd0);
        o_cls.mag_int = u;
        o_cls.int_len = byte_len64(u);
    end
endmodule
`default_nettype wire

FILE: src/nre_f32.sv
// Float32 rounding of a double magnitude and the 0.01 error check.
`default_nettype none
module nre_f32
    import nre_pkg::*;
(
    input  wire logic [62:0] i_mag,
    output t_flt             o_flt
);
    logic [10:0] e;
    logic [52:0] sig;
    logic        fe_ge1, zero, rup, ok;
    logic [5:0]  shift;
    logic [52:0] q;
    logic [53:0] rem, half, err;
    logic [24:0] q1;
    logic [35:0] r;
    logic [31:0] fb;
    logic [30:0] errs;
    logic signed [12:0] k;
    logic [83:0] lhs;

    always_comb begin
        e      = i_mag[62:52];
        sig    = {1'b1, i_mag[51:0]};
        fe_ge1 = (e >= 11'd897);
        zero   = (e == 11'd0) || (!fe_ge1 && e <= 11'd872);
        shift  = fe_ge1 ? 6'd29 : 6'(11'd926 - e);
        if (zero) shift = 6'd29;
        q    = sig >> shift;
        rem  = {1'b0, sig} & ((54'd1 << shift) - 54'd1);
        half = 54'd1 << (shift - 6'd1);
        rup  = (rem > half) || (rem == half && q[0]);
        q1   = 25'(q) + 25'(rup);
        r    = fe_ge1 ? ((36'(e - 11'd897) << 23) + 36'(q1)) : 36'(q1);
        if (zero)                 fb = '0;
        else if (r >= 36'(F32_INF)) fb = F32_INF;
        else                      fb = r[31:0];

        // rounding error in units of the double's last place
        err  = rup ? ((half << 1) - rem) : rem;
        errs = err[30:0];
        k    = $signed({2'b00, e}) - 13'sd1016;
        lhs  = 84'(errs) << k[5:0];
        if (k >= 0) begin
            ok = (k >= 13'sd53) ? (errs == 31'd0) : (lhs < 84'(ERR_MANT));
        end else begin
            // below 2^-7 the limit spans more than 2^52 last places
            ok = 1'b1;
        end
        o_flt.fbits      = fb;
        o_flt.use_double = (fb >= F32_INF) || (fb[30:23] != 8'd0 && !ok);
    end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the numeric record encoder: directed and randomized stream traffic against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import nre_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int PAUSE_AT     = 300;
    localparam int PHASE_LEN    = 700;

    typedef struct {
        logic [7:0]  header_byte;
        logic [2:0]  delta_length;
        logic [31:0] delta_copy;
        logic [63:0] payload;
        logic [3:0]  payload_length;
    } t_rec;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [31:0] delta, [95:32] value_bits
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [7:0] header_byte, [10:8] delta_length, [42:11] delta_copy,
    // [106:43] payload, [110:107] payload_length, [111] zero
    logic [M_DATA_W-1:0] m_axis_tdata;

    logic [S_DATA_W-1:0] pending_requests[$];
    t_rec                expected_records[$];
    int                  sent_cnt = 0;
    int                  recv_cnt = 0;
    int                  mismatches = 0;

    numeric_record_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Positive finite double magnitude to float32 bits, round to nearest even.
    function automatic logic [31:0] round_to_f32(input logic [63:0] mag);
        logic [63:0] sig, q, rem, half, r;
        int          fe, shift;
        if (mag[62:52] == 11'd0) return 32'd0;
        sig = {11'd0, 1'b1, mag[51:0]};
        fe = int'(mag[62:52]) - 1023 + 127;
        shift = (fe >= 1) ? 29 : 30 - fe;
        if (shift >= 54) return 32'd0;
        q = sig >> shift;
        rem = sig & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        r = (fe >= 1) ? ((64'(fe - 1) << 23) + q) : q;
        if (r >= 64'(F32_INF)) return F32_INF;
        return r[31:0];
    endfunction

    function automatic t_rec encode_record(input logic [31:0] delta, input logic [63:0] vbits);
        t_rec        rec;
        logic [63:0] mag, sig, u, db;
        logic [31:0] fb;
        logic [3:0]  n;
        logic        sgn, is_int, use_double;
        int          ex, sh;
        real         err;
        sgn = vbits[63];
        mag = {1'b0, vbits[62:0]};
        u = 64'd0;
        is_int = 1'b0;
        rec.delta_copy = delta;
        rec.delta_length = (delta[31:24] != 0) ? 3'd4 : (delta[23:16] != 0) ? 3'd3 :
                           (delta[15:8] != 0) ? 3'd2 : 3'd1;
        rec.header_byte = {6'd0, 2'(rec.delta_length - 3'd1)};
        rec.payload = 64'd0;
        rec.payload_length = PLEN_NONE;
        if (vbits[62:52] == EXP_SPECIAL) begin
            rec.header_byte |= 8'h0C;
            if (sgn && vbits[51:0] == 52'd0) rec.header_byte |= 8'h10;
        end else begin
            if (vbits[62:52] == 11'd0) begin
                is_int = (vbits[51:0] == 52'd0);
            end else begin
                ex = int'(vbits[62:52]) - 1023;
                if (ex >= 0 && ex < 64) begin
                    sig = {11'd0, 1'b1, vbits[51:0]};
                    if (ex >= 52) begin
                        u = sig << (ex - 52);
                        is_int = 1'b1;
                    end else begin
                        sh = 52 - ex;
                        if ((sig & ((64'd1 << sh) - 64'd1)) == 64'd0) begin
                            u = sig >> sh;
                            is_int = 1'b1;
                        end
                    end
                end
            end
            if (is_int && u <= TINY_LIMIT && (!sgn || u == 64'd0)) begin
                rec.header_byte |= 8'h08 | {u[3:0], 4'd0};
            end else if (is_int) begin
                n = 4'd1;
                for (int b = 1; b < 8; b++) if (u[8*b +: 8] != 8'd0) n = 4'(b + 1);
                rec.header_byte |= {sgn, 3'(n - 4'd1), 4'd0};
                rec.payload = u;
                rec.payload_length = n;
            end else begin
                fb = round_to_f32(mag);
                if (fb >= F32_INF) begin
                    use_double = 1'b1;
                end else if (fb[30:23] == 8'd0) begin
                    use_double = 1'b0;
                end else begin
                    db = ((64'(fb[30:23]) + 64'd896) << 52) | (64'(fb[22:0]) << 29);
                    err = $bitstoreal(mag) - $bitstoreal(db);
                    if (err < 0.0) err = -err;
                    use_double = !(err < 0.01);
                end
                rec.header_byte |= {2'b00, use_double, sgn, 4'b0100};
                rec.payload = use_double ? mag : {32'd0, fb};
                rec.payload_length = use_double ? PLEN_DOUBLE : PLEN_FLOAT;
            end
        end
        return rec;
    endfunction

    function automatic logic [31:0] random_delta();
        logic [31:0] d;
        d = $urandom;
        case ($urandom_range(0, 3))
            0: d = d & 32'h0000_00FF;
            1: d = d & 32'h0000_FFFF;
            2: d = d & 32'h00FF_FFFF;
            default: ;
        endcase
        return d;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: begin // small integers around the tiny range, either sign
                k = $urandom_range(0, 9);
                v = (k == 0) ? 64'd0 : {1'b0, 11'(1023 + 3), 52'd0};
                if (k != 0) begin
                    k = $urandom_range(0, 3);
                    v[62:52] = 11'(1023 + k);
                    v[51:0] = 52'(64'($urandom_range(0, 7)) << (52 - k)) &
                              52'hF_FFFF_FFFF_FFFF;
                end
                v[63] = 1'($urandom_range(0, 1));
            end
            1: begin // integers of any size up to and past 2^64
                k = $urandom_range(0, 66);
                v[62:52] = 11'(1023 + k);
                if (k < 52) v[51:0] = v[51:0] & ~((52'd1 << (52 - k)) - 52'd1);
            end
            2: v[62:52] = 11'($urandom_range(1023 - 30, 1023 + 30));
            3: begin // infinities and NaNs
                v[62:52] = EXP_SPECIAL;
                if ($urandom_range(0, 1)) v[51:0] = 52'd0;
            end
            4: v[62:52] = 11'd0;
            5: begin // exactly representable as float32, or halfway between two float32 values
                v[62:52] = 11'($urandom_range(1023 - 40, 1023 + 40));
                v[28:0] = 29'd0;
                if ($urandom_range(0, 1)) v[28] = 1'b1;
            end
            6: v[62:52] = 11'($urandom_range(1023 + 12, 1023 + 22));
            7: v[62:52] = ($urandom_range(0, 1)) ? 11'($urandom_range(1023 + 125, 1023 + 129))
                                                 : 11'($urandom_range(1023 - 152, 1023 - 124));
            default: ;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", recv_cnt, what, got, want);
        mismatches++;
    endtask

    // Request driver
    always @(posedge i_clk) begin : drive
        int sent_next;
        int idle_pct;
        sent_next = sent_cnt;
        idle_pct = (sent_cnt < PHASE_LEN) ? 25 : (sent_cnt < 2 * PHASE_LEN) ? 86 : 0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_records.push_back(encode_record(s_axis_tdata[31:0],
                                                         s_axis_tdata[95:32]));
                sent_next = sent_cnt + 1;
                sent_cnt <= sent_next;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                // hold once until everything sent so far has come back
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                    !(sent_next == PAUSE_AT && recv_cnt != sent_next)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_requests.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : monitor
        t_rec want;
        int   idle_pct;
        idle_pct = (sent_cnt < PHASE_LEN) ? 86 : (sent_cnt < 2 * PHASE_LEN) ? 25 : 0;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                recv_cnt <= recv_cnt + 1;
                if (expected_records.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
                end else begin
                    want = expected_records.pop_front();
                    if (m_axis_tdata[7:0] != want.header_byte)
                        report_mismatch("header_byte", 64'(m_axis_tdata[7:0]),
                                        64'(want.header_byte));
                    if (m_axis_tdata[10:8] != want.delta_length)
                        report_mismatch("delta_length", 64'(m_axis_tdata[10:8]),
                                        64'(want.delta_length));
                    if (m_axis_tdata[42:11] != want.delta_copy)
                        report_mismatch("delta_copy", 64'(m_axis_tdata[42:11]),
                                        64'(want.delta_copy));
                    if (m_axis_tdata[106:43] != want.payload)
                        report_mismatch("payload", m_axis_tdata[106:43], want.payload);
                    if (m_axis_tdata[110:107] != want.payload_length)
                        report_mismatch("payload_length", 64'(m_axis_tdata[110:107]),
                                        64'(want.payload_length));
                end
            end
        end
    end

    initial begin
        logic [63:0] directed_values[$];
        logic [31:0] directed_deltas[8];
        directed_deltas = '{32'h0, 32'hFF, 32'h100, 32'hFFFF, 32'h1_0000, 32'hFF_FFFF,
                            32'h100_0000, 32'hFFFF_FFFF};
        directed_values = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                            64'h3FF0_0000_0000_0000, 64'h401C_0000_0000_0000,
                            64'hBFF0_0000_0000_0000, 64'hC01C_0000_0000_0000,
                            64'h4020_0000_0000_0000, 64'h406F_E000_0000_0000,
                            64'h4070_0000_0000_0000, 64'h43E0_0000_0000_0000,
                            64'h43EF_FFFF_FFFF_FFFF, 64'h43F0_0000_0000_0000,
                            64'h3FE0_0000_0000_0000, 64'hBFB9_9999_9999_999A,
                            64'h7FF8_0000_0000_0000, 64'hFFF8_0000_0000_0001,
                            64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                            64'h7E37_E43C_8800_759C, 64'h0000_0000_0000_0001,
                            64'h37A1_6C26_2777_579C, 64'h4009_21FB_5444_2D18,
                            64'h40FE_240C_9FBE_76C9, 64'h7FEF_FFFF_FFFF_FFFF};
        foreach (directed_values[i])
            pending_requests.push_back({directed_values[i], directed_deltas[i % 8]});
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_requests.push_back({random_value(), random_delta()});
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_requests.size() != 0 || s_axis_tvalid || recv_cnt != sent_cnt)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_records.size() == 0) begin
            $display("[numeric_record_encoder] OK");
        end else begin
            $display("[numeric_record_encoder] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[numeric_record_encoder] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
